### hdl/edm_pkg.sv
// Package for the pairwise Euclidean distance matrix block.
// Holds payload structs, pipeline token types, sequencer states and constants.
// No dependencies.
package edm_pkg;

  localparam int DEF_MAX_POINTS   = 16;
  localparam int DEF_MAX_FEATURES = 16;

  localparam int FEAT_W   = 16;
  localparam int FPP_W    = 5;
  localparam int DIST_W   = 19;
  localparam int IDX_W    = 4;
  localparam int SQ_W     = 32;

  localparam logic [FPP_W-1:0]  FPP_RESET = 5'd16;
  localparam logic [DIST_W-1:0] DIST_MAX  = 19'h7FFFF;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_value;
    logic                     start_new_set;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  column_index;
    logic              last_of_row;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
    logic             last_of_row;
    logic             overflow;
  } tag_t;

  // One slot of the feature pipeline: a feature pair or a zero-distance entry.
  typedef struct packed {
    logic vld;
    logic first;
    logic lastf;
    logic zero;
    tag_t tag;
  } tok_t;

  typedef struct packed {
    logic vld;
    tag_t tag;
  } ctl_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

endpackage

### hdl/pairwise_euclidean_distance_matrix.sv
// Pairwise Euclidean distance matrix: top level with point store and root chain.
// Depends on edm_pkg, edm_ram, edm_seq and edm_sqrt_cell.
// Each distance passes the feature datapath and a chain of RW root cells
// (RW = root bits, 18 at default sizes). After the last feature of a point, the
// walker reads the f features (f = features per point) of each of the p points
// already stored, then issues the closing diagonal entry. Features of a new point
// are taken only while the walker is idle; the root chain may still drain.
// Reset (synchronous, rst_n low) empties the set, clears the feature position and
// loads 16 features per point; the point memory holds garbage until written.
module pairwise_euclidean_distance_matrix
  import edm_pkg::*;
#(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [FPP_W-1:0] cfg_wdata
);

  localparam int PI_W  = $clog2(MAX_POINTS);
  localparam int PS_W  = $clog2(MAX_POINTS + 1);
  localparam int FI_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FW    = $clog2(MAX_FEATURES + 1);
  localparam int DEPTH = MAX_POINTS * MAX_FEATURES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = SQ_W + ((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 0);
  localparam int RW    = (SUM_W + 1) / 2;
  localparam int CW    = (RW > DIST_W) ? RW : DIST_W;

  // Configuration and front-end state.
  logic [FPP_W-1:0] fpp_r;
  logic [PS_W-1:0]  pts_r, pts_nxt, pts_eff;
  logic [FI_W-1:0]  fpos_r, fpos_nxt, pos_eff;
  logic [FW-1:0]    eff_f;
  logic             in_fire, full, last_feat, we;
  logic [AW-1:0]    waddr;
  int               f_int;

  // Walker and chain signals.
  logic              adv, seq_busy, rd_en;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic [FEAT_W-1:0] rd_data_a, rd_data_b;
  ctl_t              seq_ctl;
  logic [SUM_W-1:0]  seq_sum;
  ctl_t              ctl_c [RW+1];
  logic [SUM_W-1:0]  rem_c [RW+1];
  logic [RW-1:0]     q_c   [RW+1];

  logic              out_valid_r;
  out_t              out_data_r;
  logic [CW-1:0]     root_ext;

  // Hold the whole pipeline while a finished result waits at the output.
  assign adv      = !out_valid_r || out_ready;
  // Take features only while the walker is idle; the chain may still drain.
  assign in_ready = !seq_busy;
  assign in_fire  = in_valid && in_ready;

  // Clamp the configured feature count into 1..MAX_FEATURES.
  always_comb begin
    f_int = int'(fpp_r);
    if (f_int == 0) f_int = 1;
    if (f_int > MAX_FEATURES) f_int = MAX_FEATURES;
    eff_f = FW'(f_int);
  end

  // A start flag empties the set before this feature is placed.
  always_comb begin
    pts_eff   = in_data.start_new_set ? '0 : pts_r;
    pos_eff   = in_data.start_new_set ? '0 : fpos_r;
    full      = (int'(pts_eff) >= MAX_POINTS);
    last_feat = ((int'(pos_eff) + 1) >= int'(eff_f));
    we        = in_fire && !full;
    waddr     = AW'(int'(pts_eff) * MAX_FEATURES + int'(pos_eff));
    fpos_nxt  = fpos_r;
    pts_nxt   = pts_r;
    if (in_fire) begin
      if (!last_feat) begin
        fpos_nxt = pos_eff + FI_W'(1);
        pts_nxt  = pts_eff;
      end else begin
        fpos_nxt = '0;
        pts_nxt  = full ? pts_eff : pts_eff + PS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpp_r  <= FPP_RESET;
      pts_r  <= '0;
      fpos_r <= '0;
    end else begin
      if (cfg_we) begin
        fpp_r <= cfg_wdata;
      end
      pts_r  <= pts_nxt;
      fpos_r <= fpos_nxt;
    end
  end

  edm_ram #(
    .WIDTH (FEAT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_data.feature_value),
    .re      (rd_en),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  // A dropped point launches a single overflow entry through the same path.
  edm_seq #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .job_go    (in_fire && last_feat),
    .job_p     (full ? '0 : PI_W'(pts_eff)),
    .job_f     (eff_f),
    .job_ovf   (full),
    .busy      (seq_busy),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .ctl_o     (seq_ctl),
    .sum_o     (seq_sum)
  );

  // Root chain: one cell per root bit, most significant first.
  assign ctl_c[0] = seq_ctl;
  assign rem_c[0] = seq_sum;
  assign q_c[0]   = '0;

  for (genvar k = 0; k < RW; k++) begin : g_root
    edm_sqrt_cell #(
      .SUM_W (SUM_W),
      .RW    (RW),
      .BIT   (RW - 1 - k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_c[k]),
      .rem_i (rem_c[k]),
      .q_i   (q_c[k]),
      .ctl_o (ctl_c[k+1]),
      .rem_o (rem_c[k+1]),
      .q_o   (q_c[k+1])
    );
  end

  // Saturate the root to the distance field.
  assign root_ext = CW'(q_c[RW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_c[RW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.distance     <= (root_ext > CW'(DIST_MAX)) ? DIST_MAX
                                                           : DIST_W'(root_ext);
      out_data_r.row_index    <= ctl_c[RW].tag.row_index;
      out_data_r.column_index <= ctl_c[RW].tag.column_index;
      out_data_r.last_of_row  <= ctl_c[RW].tag.last_of_row;
      out_data_r.overflow     <= ctl_c[RW].tag.overflow;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Overflow entries carry a fixed shape.
  a_ovf_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.overflow |->
      out_data_r.last_of_row && (out_data_r.distance == '0) &&
      (out_data_r.row_index == '0) && (out_data_r.column_index == '0))
    else $error("overflow result malformed");

  // The closing entry of a row is the zero diagonal.
  a_diag_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_of_row && !out_data_r.overflow |->
      (out_data_r.row_index == out_data_r.column_index) &&
      (out_data_r.distance == '0))
    else $error("diagonal result malformed");

  // The stored point count never passes capacity.
  a_pts_bound : assert property (@(posedge clk) disable iff (!rst_n)
    int'(pts_r) <= MAX_POINTS)
    else $error("point count beyond capacity");

  // No new point is taken while the walker still reads the store.
  a_no_take_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_feat |=> seq_busy && !in_ready)
    else $error("walker not started after last feature");

endmodule

### hdl/edm_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module edm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### hdl/edm_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
// Depends on edm_pkg.
module edm_sqrt_cell
  import edm_pkg::*;
#(
  parameter int SUM_W = 36,
  parameter int RW    = 18,
  parameter int BIT   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  ctl_t             ctl_i,
  input  logic [SUM_W-1:0] rem_i,
  input  logic [RW-1:0]    q_i,
  output ctl_t             ctl_o,
  output logic [SUM_W-1:0] rem_o,
  output logic [RW-1:0]    q_o
);

  localparam int TW = 2 * RW + 2;

  ctl_t             ctl_r;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [RW-1:0]    q_r, q_nxt;
  logic [TW-1:0]    trial, rem_ext;

  // Take the bit when (q + 2^BIT)^2 still fits under the radicand.
  always_comb begin
    trial   = (TW'(q_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    rem_ext = TW'(rem_i);
    if (rem_ext >= trial) begin
      rem_nxt = SUM_W'(rem_ext - trial);
      q_nxt   = q_i | (RW'(1) << BIT);
    end else begin
      rem_nxt = rem_i;
      q_nxt   = q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

### hdl/edm_seq.sv
// Row walker and feature datapath: reads pairs of features, squares the
// differences and sums them per row. Depends on edm_pkg.
module edm_seq
  import edm_pkg::*;
#(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  localparam int PI_W  = $clog2(MAX_POINTS),
  localparam int FI_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int FW    = $clog2(MAX_FEATURES + 1),
  localparam int AW    = $clog2(MAX_POINTS * MAX_FEATURES),
  localparam int SUM_W = SQ_W + ((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 0)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              job_go,
  input  logic [PI_W-1:0]   job_p,
  input  logic [FW-1:0]     job_f,
  input  logic              job_ovf,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr_a,
  output logic [AW-1:0]     rd_addr_b,
  input  logic [FEAT_W-1:0] rd_data_a,
  input  logic [FEAT_W-1:0] rd_data_b,
  output ctl_t              ctl_o,
  output logic [SUM_W-1:0]  sum_o
);

  seq_state_t state_r, state_nxt;
  logic [PI_W-1:0] row_r, p_r;
  logic [FI_W-1:0] feat_r;
  logic [FW-1:0]   f_r;
  logic            ovf_r;
  logic            at_diag, feat_last, issue;
  tok_t            tok0, tok1_r, tok2_r, tok3_r;
  logic signed [FEAT_W:0]     diff_r, diff_nxt;
  logic signed [2*FEAT_W+1:0] prod;
  logic [SQ_W-1:0]  sq_r;
  logic [SUM_W-1:0] acc_r, acc_sum, sum_r;
  ctl_t             ctl_r;

  assign at_diag   = (row_r == p_r);
  assign feat_last = ((FW'(feat_r) + FW'(1)) >= f_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: if (job_go) state_nxt = SEQ_RUN;
      SEQ_RUN:  if (adv && at_diag) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_r == SEQ_RUN);
    issue = busy && adv;
    rd_en = adv;
    rd_addr_a = AW'(int'(row_r) * MAX_FEATURES + int'(feat_r));
    rd_addr_b = AW'(int'(p_r) * MAX_FEATURES + int'(feat_r));
    tok0.vld   = issue;
    tok0.first = at_diag || (feat_r == '0);
    tok0.lastf = at_diag || feat_last;
    tok0.zero  = at_diag;
    tok0.tag.row_index    = IDX_W'(at_diag ? p_r : row_r);
    tok0.tag.column_index = IDX_W'(p_r);
    tok0.tag.last_of_row  = at_diag;
    tok0.tag.overflow     = at_diag && ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      row_r   <= '0;
      feat_r  <= '0;
      p_r     <= '0;
      f_r     <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (job_go && !busy) begin
        row_r  <= '0;
        feat_r <= '0;
        p_r    <= job_p;
        f_r    <= job_f;
        ovf_r  <= job_ovf;
      end else if (issue && !at_diag) begin
        if (feat_last) begin
          feat_r <= '0;
          row_r  <= row_r + PI_W'(1);
        end else begin
          feat_r <= feat_r + FI_W'(1);
        end
      end
    end
  end

  // Datapath: RAM read, difference, square, accumulate.
  assign diff_nxt = tok1_r.zero ? '0 :
                    ($signed({rd_data_a[FEAT_W-1], rd_data_a}) -
                     $signed({rd_data_b[FEAT_W-1], rd_data_b}));
  assign prod    = diff_r * diff_r;
  assign acc_sum = (tok3_r.first ? '0 : acc_r) + SUM_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
      tok3_r <= '0;
      ctl_r  <= '0;
    end else if (adv) begin
      tok1_r    <= tok0;
      tok2_r    <= tok1_r;
      tok3_r    <= tok2_r;
      ctl_r.vld <= tok3_r.vld && tok3_r.lastf;
      ctl_r.tag <= tok3_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r <= diff_nxt;
      sq_r   <= prod[SQ_W-1:0];
      if (tok3_r.vld) begin
        acc_r <= acc_sum;
        sum_r <= acc_sum;
      end
    end
  end

  assign ctl_o = ctl_r;
  assign sum_o = sum_r;

endmodule
